// ===== src/rrec_pkg.sv =====
package rrec_pkg;

  // coordinate and distance width inside the datapath, in 1/32 px
  localparam int CRD_W = 24;

  // square root unit
  localparam int SQ_IN_W  = 40;
  localparam int SQ_OUT_W = 20;
  localparam int SQ_STEPS = SQ_OUT_W;

  // restoring divider unit
  localparam int DIV_N_W = 34;
  localparam int DIV_D_W = 21;
  localparam int DIV_Q_W = 16;

  typedef logic signed [CRD_W-1:0] crd_t;

  // effect kinds
  typedef enum logic [1:0] {
    KIND_OUTER   = 2'd0,
    KIND_INSET   = 2'd1,
    KIND_OUTLINE = 2'd2
  } kind_t;

  // register map, word index
  typedef enum logic [2:0] {
    REG_EFFECT_KIND      = 3'd0,
    REG_SHAPE_ORIGIN     = 3'd1,
    REG_SHAPE_SIZE       = 3'd2,
    REG_CORNER_RADIUS    = 3'd3,
    REG_SHADOW_OFFSET    = 3'd4,
    REG_BLUR_AND_SPREAD  = 3'd5,
    REG_OUTLINE_GEOMETRY = 3'd6,
    REG_ANTIALIAS_WIDTH  = 3'd7
  } reg_idx_t;

  // gaussian tail, 0.5*erfc(u/sqrt2) over [0,4] in steps of 1/8, scaled by 65536
  function automatic logic [15:0] erfc_q(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0:  v = 16'd32768;
      6'd1:  v = 16'd29508;
      6'd2:  v = 16'd26299;
      6'd3:  v = 16'd23189;
      6'd4:  v = 16'd20220;
      6'd5:  v = 16'd17432;
      6'd6:  v = 16'd14852;
      6'd7:  v = 16'd12503;
      6'd8:  v = 16'd10398;
      6'd9:  v = 16'd8539;
      6'd10: v = 16'd6924;
      6'd11: v = 16'd5542;
      6'd12: v = 16'd4378;
      6'd13: v = 16'd3413;
      6'd14: v = 16'd2625;
      6'd15: v = 16'd1992;
      6'd16: v = 16'd1491;
      6'd17: v = 16'd1101;
      6'd18: v = 16'd801;
      6'd19: v = 16'd575;
      6'd20: v = 16'd407;
      6'd21: v = 16'd284;
      6'd22: v = 16'd195;
      6'd23: v = 16'd132;
      6'd24: v = 16'd88;
      6'd25: v = 16'd58;
      6'd26: v = 16'd38;
      6'd27: v = 16'd24;
      6'd28: v = 16'd15;
      6'd29: v = 16'd9;
      6'd30: v = 16'd6;
      6'd31: v = 16'd3;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

// ===== src/rrec_pix_if.sv =====
interface rrec_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== src/rrec_cov_if.sv =====
interface rrec_cov_if;
  logic       valid;
  logic       ready;
  logic [7:0] coverage;

  modport source (output valid, output coverage, input ready);
  modport sink (input valid, input coverage, output ready);
endinterface

// ===== src/rrec_sqrt.sv =====
module rrec_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rrec_pkg::SQ_IN_W-1:0]  n_i,
  output logic [rrec_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int XW = rrec_pkg::SQ_IN_W + 1;
  localparam int NS = rrec_pkg::SQ_STEPS;

  logic [XW-1:0] x_r [NS];
  logic [XW-1:0] r_r [NS];
  logic [XW-1:0] x_in [NS];
  logic [XW-1:0] r_in [NS];
  logic [XW-1:0] x_nxt [NS];
  logic [XW-1:0] r_nxt [NS];
  logic [rrec_pkg::SQ_OUT_W-1:0] root_r;

  function automatic logic [XW-1:0] sq_bit(input int i);
    return XW'(1) << (rrec_pkg::SQ_IN_W - 2 - 2 * i);
  endfunction

  // one result bit per stage
  always_comb begin
    x_in[0] = XW'(n_i);
    r_in[0] = '0;
    for (int i = 1; i < NS; i++) begin
      x_in[i] = x_r[i-1];
      r_in[i] = r_r[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      if (x_in[i] >= r_in[i] + sq_bit(i)) begin
        x_nxt[i] = x_in[i] - r_in[i] - sq_bit(i);
        r_nxt[i] = (r_in[i] >> 1) + sq_bit(i);
      end else begin
        x_nxt[i] = x_in[i];
        r_nxt[i] = r_in[i] >> 1;
      end
    end
  end

  // stage registers and round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        x_r[i] <= x_nxt[i];
        r_r[i] <= r_nxt[i];
      end
      root_r <= rrec_pkg::SQ_OUT_W'(r_r[NS-1] + XW'(x_r[NS-1] > r_r[NS-1]));
    end
  end

  assign root_o = root_r;

endmodule

// ===== src/rrec_div.sv =====
module rrec_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rrec_pkg::DIV_N_W-1:0] num_i,
  input  logic [rrec_pkg::DIV_D_W-1:0] den_i,
  output logic [rrec_pkg::DIV_Q_W-1:0] quo_o
);

  localparam int NW = rrec_pkg::DIV_N_W;
  localparam int DW = rrec_pkg::DIV_D_W;
  localparam int QW = rrec_pkg::DIV_Q_W;
  localparam int CW = DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [NW-1:0] rem_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [NW-1:0] rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic [CW-1:0] sh [QW];

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    rem_in[0] = num_i;
    quo_in[0] = '0;
    den_in[0] = den_i;
    for (int s = 1; s < QW; s++) begin
      rem_in[s] = rem_r[s-1];
      quo_in[s] = quo_r[s-1];
      den_in[s] = den_r[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      sh[s] = CW'(den_in[s]) << (QW - 1 - s);
      if (CW'(rem_in[s]) >= sh[s]) begin
        rem_nxt[s] = rem_in[s] - sh[s][NW-1:0];
        quo_nxt[s] = quo_in[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_nxt[s] = rem_in[s];
        quo_nxt[s] = quo_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_in[s];
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

// ===== src/rounded_rect_effect_coverage.sv =====
// Rounded-rectangle effect coverage, one sample point per beat.
// in_if carries a signed 12.4 sample point (pixel_x, pixel_y); out_if returns
// one 8-bit coverage beat for every input beat, in order.
// The effect (outer shadow, inset shadow or outline) and its geometry sit in
// eight 32-bit registers on the APB port at byte address 4*index; pready is
// always high and reads return the register value. Registers are to be written
// only while no beat is in flight; the user must keep to this, as the block
// itself does not enforce it. One beat enters per cycle unless the output
// stalls. The depth is set by the 20-stage square root (plus rounding) for
// the corner distance and the 16-stage restoring dividers for the gaussian
// table index and the outline ramps, each taking one bit per stage.
// The pipeline advances as a whole: when the output beat is not taken, every
// stage holds and in_if.ready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads register
// defaults: outer shadow, all geometry zero, antialias width 16 (one pixel).
module rounded_rect_effect_coverage (
  input  logic              clk,
  input  logic              rst_n,
  rrec_pix_if.sink          in_if,
  rrec_cov_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NSTG = 50;
  localparam int CW   = rrec_pkg::CRD_W;
  localparam int GW   = 26;
  localparam int SQD  = rrec_pkg::SQ_STEPS + 1;
  localparam int DVD  = rrec_pkg::DIV_Q_W;

  typedef struct packed {
    logic gz;
    logic gzv;
    logic gforce;
    logic ghi;
    logic tf1;
    logic tv1;
    logic tf2;
    logic tv2;
    logic cov_en;
  } side_t;

  function automatic rrec_pkg::crd_t sx2(input logic [15:0] v);
    return {{(CW-17){v[15]}}, v, 1'b0};
  endfunction

  function automatic rrec_pkg::crd_t ux2(input logic [15:0] v);
    return {{(CW-17){1'b0}}, v, 1'b0};
  endfunction

  // configuration registers
  logic [1:0]  kind_r;
  logic [31:0] origin_r, size_r, offset_r, blursp_r, outline_r;
  logic [15:0] radius_r, aa_r;

  logic wr_en;
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= rrec_pkg::KIND_OUTER;
      origin_r  <= '0;
      size_r    <= '0;
      radius_r  <= '0;
      offset_r  <= '0;
      blursp_r  <= '0;
      outline_r <= '0;
      aa_r      <= 16'd16;
    end else if (wr_en) begin
      case (rrec_pkg::reg_idx_t'(paddr[4:2]))
        rrec_pkg::REG_EFFECT_KIND:      kind_r    <= pwdata[1:0];
        rrec_pkg::REG_SHAPE_ORIGIN:     origin_r  <= pwdata;
        rrec_pkg::REG_SHAPE_SIZE:       size_r    <= pwdata;
        rrec_pkg::REG_CORNER_RADIUS:    radius_r  <= pwdata[15:0];
        rrec_pkg::REG_SHADOW_OFFSET:    offset_r  <= pwdata;
        rrec_pkg::REG_BLUR_AND_SPREAD:  blursp_r  <= pwdata;
        rrec_pkg::REG_OUTLINE_GEOMETRY: outline_r <= pwdata;
        rrec_pkg::REG_ANTIALIAS_WIDTH:  aa_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (rrec_pkg::reg_idx_t'(paddr[4:2]))
      rrec_pkg::REG_EFFECT_KIND:      prdata = {30'b0, kind_r};
      rrec_pkg::REG_SHAPE_ORIGIN:     prdata = origin_r;
      rrec_pkg::REG_SHAPE_SIZE:       prdata = size_r;
      rrec_pkg::REG_CORNER_RADIUS:    prdata = {16'b0, radius_r};
      rrec_pkg::REG_SHADOW_OFFSET:    prdata = offset_r;
      rrec_pkg::REG_BLUR_AND_SPREAD:  prdata = blursp_r;
      rrec_pkg::REG_OUTLINE_GEOMETRY: prdata = outline_r;
      rrec_pkg::REG_ANTIALIAS_WIDTH:  prdata = {16'b0, aa_r};
      default:                        prdata = '0;
    endcase
  end

  // shape geometry from the registers, to be held static by the user while beats are in flight
  rrec_pkg::crd_t xa, ya, wa, ha, ra, mna, rra, hwa, hha, cxa, cya, hqxa, hqya;
  rrec_pkg::crd_t xb, yb, wb, hb, rbr, mnb, halfb, rrb, hwb, hhb, cxb, cyb, hqxb, hqyb;
  rrec_pkg::crd_t offx, offy, blur, spr;
  logic valid_a, valid_b;

  always_comb begin
    xa   = sx2(origin_r[15:0]);
    ya   = sx2(origin_r[31:16]);
    wa   = ux2(size_r[15:0]);
    ha   = ux2(size_r[31:16]);
    ra   = ux2(radius_r);
    offx = sx2(offset_r[15:0]);
    offy = sx2(offset_r[31:16]);
    blur = ux2(blursp_r[15:0]);
    spr  = sx2(blursp_r[31:16]);

    valid_a = (wa != 0) && (ha != 0);
    mna  = (wa < ha) ? wa : ha;
    rra  = (ra > (mna >>> 1)) ? (mna >>> 1) : ra;
    hwa  = wa >>> 1;
    hha  = ha >>> 1;
    cxa  = xa + hwa;
    cya  = ya + hha;
    hqxa = hwa - rra;
    hqya = hha - rra;

    // outer shadow grows by the spread, both shadows shift by the offset
    if (kind_r == rrec_pkg::KIND_OUTER) begin
      wb  = wa + (spr <<< 1);
      hb  = ha + (spr <<< 1);
      xb  = xa - spr + offx;
      yb  = ya - spr + offy;
      rbr = ra + spr;
    end else begin
      wb  = wa;
      hb  = ha;
      xb  = xa + offx;
      yb  = ya + offy;
      rbr = ra;
    end
    valid_b = (wb > 0) && (hb > 0);
    mnb   = (wb < hb) ? wb : hb;
    halfb = mnb >>> 1;
    rrb   = (rbr < 0) ? '0 : ((rbr > halfb) ? halfb : rbr);
    hwb   = wb >>> 1;
    hhb   = hb >>> 1;
    cxb   = xb + hwb;
    cyb   = yb + hhb;
    hqxb  = hwb - rrb;
    hqyb  = hhb - rrb;
  end

  // pipeline advance and valid bits
  logic              en;
  logic [NSTG:1]     vld_r;

  assign en          = !vld_r[NSTG] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:1], in_if.valid};
    end
  end

  // stage 1: distance from centers
  rrec_pkg::crd_t px, py, dxa, dya, dxb, dyb;
  rrec_pkg::crd_t s1_axa_r, s1_aya_r, s1_axb_r, s1_ayb_r;

  always_comb begin
    px  = sx2(in_if.pixel_x);
    py  = sx2(in_if.pixel_y);
    dxa = px - cxa;
    dya = py - cya;
    dxb = px - cxb;
    dyb = py - cyb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_axa_r <= (dxa < 0) ? -dxa : dxa;
      s1_aya_r <= (dya < 0) ? -dya : dya;
      s1_axb_r <= (dxb < 0) ? -dxb : dxb;
      s1_ayb_r <= (dyb < 0) ? -dyb : dyb;
    end
  end

  // stage 2: corner offsets and inner distance
  rrec_pkg::crd_t qxa, qya, qxb, qyb, mxa, mxb;
  logic [19:0]    s2_oxa_r, s2_oya_r, s2_oxb_r, s2_oyb_r;
  rrec_pkg::crd_t s2_insa_r, s2_insb_r;

  always_comb begin
    qxa = s1_axa_r - hqxa;
    qya = s1_aya_r - hqya;
    qxb = s1_axb_r - hqxb;
    qyb = s1_ayb_r - hqyb;
    mxa = (qxa > qya) ? qxa : qya;
    mxb = (qxb > qyb) ? qxb : qyb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_oxa_r  <= (qxa > 0) ? qxa[19:0] : '0;
      s2_oya_r  <= (qya > 0) ? qya[19:0] : '0;
      s2_oxb_r  <= (qxb > 0) ? qxb[19:0] : '0;
      s2_oyb_r  <= (qyb > 0) ? qyb[19:0] : '0;
      s2_insa_r <= (mxa > 0) ? '0 : mxa;
      s2_insb_r <= (mxb > 0) ? '0 : mxb;
    end
  end

  // stage 3: squares
  logic [39:0]    s3_sxa_r, s3_sya_r, s3_sxb_r, s3_syb_r;
  rrec_pkg::crd_t s3_insa_r, s3_insb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sxa_r  <= 40'(s2_oxa_r) * 40'(s2_oxa_r);
      s3_sya_r  <= 40'(s2_oya_r) * 40'(s2_oya_r);
      s3_sxb_r  <= 40'(s2_oxb_r) * 40'(s2_oxb_r);
      s3_syb_r  <= 40'(s2_oyb_r) * 40'(s2_oyb_r);
      s3_insa_r <= s2_insa_r;
      s3_insb_r <= s2_insb_r;
    end
  end

  // stage 4: squared corner distance
  logic [rrec_pkg::SQ_IN_W-1:0] s4_na_r, s4_nb_r;
  rrec_pkg::crd_t               s4_insa_r, s4_insb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_na_r   <= s3_sxa_r + s3_sya_r;
      s4_nb_r   <= s3_sxb_r + s3_syb_r;
      s4_insa_r <= s3_insa_r;
      s4_insb_r <= s3_insb_r;
    end
  end

  // stages 5 to 25: rounded square roots, inner distance rides alongside
  logic [rrec_pkg::SQ_OUT_W-1:0] rta, rtb;
  rrec_pkg::crd_t                insda_r [SQD];
  rrec_pkg::crd_t                insdb_r [SQD];

  rrec_sqrt u_sqa (.clk(clk), .en(en), .n_i(s4_na_r), .root_o(rta));
  rrec_sqrt u_sqb (.clk(clk), .en(en), .n_i(s4_nb_r), .root_o(rtb));

  always_ff @(posedge clk) begin
    if (en) begin
      insda_r[0] <= s4_insa_r;
      insdb_r[0] <= s4_insb_r;
      for (int i = 1; i < SQD; i++) begin
        insda_r[i] <= insda_r[i-1];
        insdb_r[i] <= insdb_r[i-1];
      end
    end
  end

  // stage 26: signed distances
  rrec_pkg::crd_t s26_da_r, s26_db_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s26_da_r <= $signed({{(CW-rrec_pkg::SQ_OUT_W){1'b0}}, rta}) + insda_r[SQD-1] - rra;
      s26_db_r <= $signed({{(CW-rrec_pkg::SQ_OUT_W){1'b0}}, rtb}) + insdb_r[SQD-1] - rrb;
    end
  end

  // stage 27: divider operands and special cases
  rrec_pkg::crd_t   dg, oo, ow, hq, e0a, e0b, den, numa, numb;
  logic signed [GW-1:0] d2, b4, gsum;
  logic             g_lo, g_hi, tf1, tv1, tf2, tv2, cov_en;
  side_t            sd27;
  logic [rrec_pkg::DIV_N_W-1:0] s27_ng_r, s27_n1_r, s27_n2_r;
  logic [rrec_pkg::DIV_D_W-1:0] s27_dg_r, s27_den_r;
  side_t            s27_sd_r;

  always_comb begin
    dg   = (kind_r == rrec_pkg::KIND_OUTER) ? s26_db_r : (-s26_db_r - spr);
    d2   = GW'(dg) <<< 1;
    b4   = GW'(blur) <<< 2;
    gsum = d2 + b4;
    g_lo = d2 <= -b4;
    g_hi = d2 >= b4;

    oo   = ux2(outline_r[15:0]);
    ow   = ux2(outline_r[31:16]);
    hq   = {{(CW-16){1'b0}}, aa_r};
    e0a  = oo - hq;
    e0b  = oo + ow - hq;
    den  = hq <<< 1;
    numa = s26_da_r - e0a;
    numb = s26_da_r - e0b;
    tf1  = (den == 0) || (numa <= 0) || (numa >= den);
    tv1  = (den == 0) ? !(numa < 0) : (numa >= den);
    tf2  = (den == 0) || (numb <= 0) || (numb >= den);
    tv2  = (den == 0) ? !(numb < 0) : (numb >= den);

    case (kind_r)
      rrec_pkg::KIND_OUTER:   cov_en = valid_b;
      rrec_pkg::KIND_INSET:   cov_en = valid_a && valid_b && (s26_da_r <= 0);
      rrec_pkg::KIND_OUTLINE: cov_en = valid_a;
      default:                cov_en = 1'b0;
    endcase

    sd27.gz     = (blur == 0);
    sd27.gzv    = (dg <= 0);
    sd27.gforce = g_lo || g_hi;
    sd27.ghi    = g_hi && !g_lo;
    sd27.tf1    = tf1;
    sd27.tv1    = tv1;
    sd27.tf2    = tf2;
    sd27.tv2    = tv2;
    sd27.cov_en = cov_en;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // index numerator (2d+4b)*255+4b over 8b
      s27_ng_r  <= (g_lo || g_hi) ? '0 :
                   (({8'b0, gsum} << 8) - {8'b0, gsum} + {8'b0, b4});
      s27_dg_r  <= {blur[17:0], 3'b000};
      s27_n1_r  <= tf1 ? '0 : {numa[17:0], 16'b0};
      s27_n2_r  <= tf2 ? '0 : {numb[17:0], 16'b0};
      s27_den_r <= den[rrec_pkg::DIV_D_W-1:0];
      s27_sd_r  <= sd27;
    end
  end

  // stages 28 to 43: dividers, flags ride alongside
  logic [rrec_pkg::DIV_Q_W-1:0] qg, q1, q2;
  side_t                        sdd_r [DVD];

  rrec_div u_divg (.clk(clk), .en(en), .num_i(s27_ng_r), .den_i(s27_dg_r), .quo_o(qg));
  rrec_div u_div1 (.clk(clk), .en(en), .num_i(s27_n1_r), .den_i(s27_den_r), .quo_o(q1));
  rrec_div u_div2 (.clk(clk), .en(en), .num_i(s27_n2_r), .den_i(s27_den_r), .quo_o(q2));

  always_ff @(posedge clk) begin
    if (en) begin
      sdd_r[0] <= s27_sd_r;
      for (int i = 1; i < DVD; i++) begin
        sdd_r[i] <= sdd_r[i-1];
      end
    end
  end

  // stages 44 to 50: table lookup, smoothstep polynomial, final scale
  side_t       sd_in, s44_sd_r, s45_sd_r, s46_sd_r, s47_sd_r, s48_sd_r, s49_sd_r;
  logic [7:0]  s44_k_r;
  logic [16:0] s44_t1_r, s44_t2_r;
  logic        s45_ms_r, s46_ms_r, s47_ms_r, s48_ms_r;
  logic [12:0] s45_am_r;
  logic [33:0] s45_tt1_r, s45_tt2_r;
  logic [16:0] s45_t1_r, s45_t2_r;
  logic [13:0] am_w;
  logic [20:0] est_p;
  logic [4:0]  est;
  logic [12:0] rem;
  logic [5:0]  s46_i_r;
  logic [7:0]  s46_f_r;
  logic [51:0] s46_p1_r, s46_p2_r;
  logic [15:0] s47_qi_r;
  logic [19:0] s47_xx_r;
  logic        s47_i32_r, s48_i32_r;
  logic [16:0] s47_s1_r, s47_s2_r, s48_s1_r, s48_b2_r;
  logic [15:0] s48_qi_r;
  logic [28:0] est2_p;
  logic [12:0] est2;
  logic [19:0] rem2;
  logic [12:0] s48_qx_r;
  logic [16:0] v_raw, s49_v_r;
  logic [33:0] s49_ab_r;
  logic [24:0] covg_w;
  logic [41:0] covo_w;
  logic [7:0]  s50_cov_r;

  assign sd_in = sdd_r[DVD-1];

  always_comb begin
    am_w   = s44_k_r <= 8'd127 ? (14'd8160 - {s44_k_r, 6'b0}) : ({s44_k_r, 6'b0} - 14'd8160);
    est_p  = 21'(s45_am_r) * 21'd257;
    est    = est_p[20:16];
    rem    = s45_am_r - 13'(est) * 13'd255;
    est2_p = 29'(s47_xx_r) * 29'd257;
    est2   = est2_p[28:16];
    rem2   = s47_xx_r - 20'(est2) * 20'd255;
    v_raw  = s48_i32_r ? 17'd2 : (17'(s48_qi_r) - 17'(s48_qx_r));
    covg_w = 25'(s49_v_r) * 25'd255 + 25'd32768;
    covo_w = 42'(s49_ab_r) * 42'd255 + (42'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // table index and ramp positions
      s44_k_r  <= sd_in.gforce ? (sd_in.ghi ? 8'd255 : 8'd0) : qg[7:0];
      s44_t1_r <= sd_in.tf1 ? {sd_in.tv1, 16'b0} : {1'b0, q1};
      s44_t2_r <= sd_in.tf2 ? {sd_in.tv2, 16'b0} : {1'b0, q2};
      s44_sd_r <= sd_in;

      // distance from table center, t squared
      s45_ms_r  <= s44_k_r <= 8'd127;
      s45_am_r  <= am_w[12:0];
      s45_tt1_r <= 34'(s44_t1_r) * 34'(s44_t1_r);
      s45_tt2_r <= 34'(s44_t2_r) * 34'(s44_t2_r);
      s45_t1_r  <= s44_t1_r;
      s45_t2_r  <= s44_t2_r;
      s45_sd_r  <= s44_sd_r;

      // split into segment and fraction, t*t*(3-2t)
      s46_ms_r <= s45_ms_r;
      s46_i_r  <= (rem >= 13'd255) ? (6'(est) + 6'd1) : 6'(est);
      s46_f_r  <= (rem >= 13'd255) ? 8'(rem - 13'd255) : rem[7:0];
      s46_p1_r <= 52'(s45_tt1_r) * 52'(18'd196608 - {s45_t1_r, 1'b0});
      s46_p2_r <= 52'(s45_tt2_r) * 52'(18'd196608 - {s45_t2_r, 1'b0});
      s46_sd_r <= s45_sd_r;

      // table read and interpolation product, smoothstep rounding
      s47_ms_r  <= s46_ms_r;
      s47_i32_r <= s46_i_r >= 6'd32;
      s47_qi_r  <= rrec_pkg::erfc_q(s46_i_r);
      s47_xx_r  <= 20'(rrec_pkg::erfc_q(s46_i_r) - rrec_pkg::erfc_q(s46_i_r + 6'd1))
                   * 20'(s46_f_r) + 20'd127;
      s47_s1_r  <= 17'((s46_p1_r + (52'd1 << 31)) >> 32);
      s47_s2_r  <= 17'((s46_p2_r + (52'd1 << 31)) >> 32);
      s47_sd_r  <= s46_sd_r;

      // divide by 255 with one correction
      s48_ms_r  <= s47_ms_r;
      s48_i32_r <= s47_i32_r;
      s48_qi_r  <= s47_qi_r;
      s48_qx_r  <= (rem2 >= 20'd255) ? (est2 + 13'd1) : est2;
      s48_s1_r  <= s47_s1_r;
      s48_b2_r  <= 17'd65536 - s47_s2_r;
      s48_sd_r  <= s47_sd_r;

      // tail value with sign fold, ramp product
      s49_v_r  <= s48_ms_r ? (17'd65536 - v_raw) : v_raw;
      s49_ab_r <= 34'(s48_s1_r) * 34'(s48_b2_r);
      s49_sd_r <= s48_sd_r;

      // scale to 8 bits and pick the effect
      if (!s49_sd_r.cov_en) begin
        s50_cov_r <= '0;
      end else if (kind_r == rrec_pkg::KIND_OUTLINE) begin
        s50_cov_r <= covo_w[39:32];
      end else if (s49_sd_r.gz) begin
        s50_cov_r <= s49_sd_r.gzv ? 8'd255 : 8'd0;
      end else begin
        s50_cov_r <= covg_w[23:16];
      end
    end
  end

  assign out_if.valid    = vld_r[NSTG];
  assign out_if.coverage = s50_cov_r;

endmodule
